>>> sv/pcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_pkg: shared types and helpers for the pair collision resolver
// Word layouts, pair kinds, push modes, job record, and the back-end states.
// ----------------------------------------------------------------------------
package pcr_pkg;

  // Field widths of the external words.
  localparam int CW   = 24;          // coordinate width, signed fixed point
  localparam int FRAC = 8;           // fraction bits
  localparam int MW   = 16;          // collision mask width
  localparam int SW   = CW - 1;      // size field width, unsigned

  // Internal widths.
  localparam int CTW  = CW + 1;              // shape center
  localparam int DW   = CW + 3;              // center delta, signed
  localparam int MGW  = DW;                  // delta magnitude
  localparam int SQW  = 2 * MGW;             // one square
  localparam int SSW  = SQW + 1;             // sum of squares
  localparam int RTW  = MGW + 1;             // distance
  localparam int NW   = FRAC + 1;            // normal component magnitude
  localparam int LW   = SW + 1;              // radius sum or radius
  localparam int REMW = RTW + FRAC;          // divider remainder
  localparam int RAWW = MGW + FRAC;          // move magnitude before scaling
  localparam int MAGW = RAWW - FRAC;         // move magnitude after scaling
  localparam int PW   = MAGW + 1;            // signed move
  localparam int SUMW = PW + 1;              // position plus move
  localparam int CNTW = $clog2(RTW);         // step counter

  // Job queue depth.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Word codes.
  localparam logic SLOT_FIRST   = 1'b0;
  localparam logic SLOT_SECOND  = 1'b1;
  localparam logic SHAPE_CIRCLE = 1'b0;
  localparam logic SHAPE_RECT   = 1'b1;

  // Pair kinds as reported in the result word.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CC   = 2'd1;
  localparam logic [1:0] KIND_RR   = 2'd2;
  localparam logic [1:0] KIND_CR   = 2'd3;

  // Which bodies move: the plus body moves along +v, the minus body along -v.
  typedef enum logic [1:0] {
    MODE_HALF,
    MODE_PLUS_FULL,
    MODE_MINUS_FULL
  } mode_t;

  typedef struct packed {
    logic                  slot;
    logic                  body_kind;
    logic signed [CW-1:0]  body_x;
    logic signed [CW-1:0]  body_y;
    logic signed [CW-1:0]  offset_x;
    logic signed [CW-1:0]  offset_y;
    logic [SW-1:0]         size_len;
    logic [SW-1:0]         size_wid;
    logic [MW-1:0]         body_mask;
    logic                  body_static;
  } in_t;

  typedef struct packed {
    logic                  collided;
    logic [1:0]            pair_kind;
    logic signed [CW-1:0]  first_new_x;
    logic signed [CW-1:0]  first_new_y;
    logic signed [CW-1:0]  second_new_x;
    logic signed [CW-1:0]  second_new_y;
  } out_t;

  // One classified pair handed from the front end to the back end.
  typedef struct packed {
    logic [1:0]            kind;
    mode_t                 mode;
    logic                  plus_first;
    logic signed [CW-1:0]  ax;
    logic signed [CW-1:0]  ay;
    logic signed [CW-1:0]  bx;
    logic signed [CW-1:0]  by;
    logic signed [CTW-1:0] c1x;
    logic signed [CTW-1:0] c1y;
    logic signed [CTW-1:0] c2x;
    logic signed [CTW-1:0] c2y;
    logic [SW-1:0]         ex;
    logic [SW-1:0]         ey;
    logic [LW-1:0]         lim;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PREP,
    BK_CLAMP,
    BK_RECT,
    BK_SQX,
    BK_SQY,
    BK_SUM,
    BK_ROOT,
    BK_DECIDE,
    BK_DIV,
    BK_MULX,
    BK_MULY,
    BK_DONE
  } back_state_t;

  // Magnitude of a signed delta.
  function automatic logic [MGW-1:0] mag_of(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] n;
    n = -v;
    mag_of = v[DW-1] ? MGW'($unsigned(n)) : MGW'($unsigned(v));
  endfunction

  // Saturate a widened position to the coordinate range.
  function automatic logic signed [CW-1:0] sat_pos(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] hi;
    logic signed [SUMW-1:0] lo;
    hi = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = {{(SUMW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    if (v > hi) begin
      sat_pos = {1'b0, {(CW-1){1'b1}}};
    end else if (v < lo) begin
      sat_pos = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_pos = v[CW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/pair_collision_resolver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pair_collision_resolver: 2D body pair collision test and pushout
// Channel   Direction  Word    Handshake
// in_*      input      in_t    in_valid / in_ready, one body per word
// out_*     output     out_t   out_valid / out_ready, one result per pair
//
// A first-body word is held for its pair. A second-body word is classified
// in the cycle it is taken and queued; the queue holds two pairs.
// Circle and circle-rectangle pairs run the 28-step square root and, on a
// hit at nonzero distance, two normal divisions; a rectangle pair runs
// neither.
// Reset is synchronous and clears the held body, queue and sequencer.
// A stalled output holds the result register; input stalls only when full.
// ----------------------------------------------------------------------------
module pair_collision_resolver (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pcr_pkg::out_t out_data
);
  import pcr_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  // Intake and classification.
  pcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_job)
  );

  // Job queue between the two halves.
  pcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (pop_job)
  );

  // Test and pushout.
  pcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> sv/pcr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_front: body intake and pair classification
// Holds the first body, and on the second body builds a job that names the
// test to run, the centers, extents, limit and which bodies may move.
// ----------------------------------------------------------------------------
module pcr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcr_pkg::in_t  in_data,
  input  logic          q_full,
  output logic          q_push,
  output pcr_pkg::job_t q_data
);
  import pcr_pkg::*;

  in_t  held_r;
  in_t  held_nxt;
  logic take;

  // A word is taken whenever the job queue has room.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign q_push   = take && (in_data.slot == SLOT_SECOND);

  // The first body of a pair is held until the second arrives.
  always_comb begin
    held_nxt = held_r;
    if (take && (in_data.slot == SLOT_FIRST)) begin
      held_nxt = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  // Classify the pair and lay out the job for the back end.
  always_comb begin
    logic signed [CTW-1:0] cax;
    logic signed [CTW-1:0] cay;
    logic signed [CTW-1:0] cbx;
    logic signed [CTW-1:0] cby;
    logic                  mask_ok;
    logic                  a_rect;
    logic                  b_rect;
    logic                  circ_stat;
    logic                  rect_stat;
    cax       = CTW'(held_r.body_x) + CTW'(held_r.offset_x);
    cay       = CTW'(held_r.body_y) + CTW'(held_r.offset_y);
    cbx       = CTW'(in_data.body_x) + CTW'(in_data.offset_x);
    cby       = CTW'(in_data.body_y) + CTW'(in_data.offset_y);
    mask_ok   = |(held_r.body_mask & in_data.body_mask);
    a_rect    = (held_r.body_kind == SHAPE_RECT);
    b_rect    = (in_data.body_kind == SHAPE_RECT);
    circ_stat = a_rect ? in_data.body_static : held_r.body_static;
    rect_stat = a_rect ? held_r.body_static : in_data.body_static;

    q_data            = '0;
    q_data.mode       = MODE_HALF;
    q_data.ax         = held_r.body_x;
    q_data.ay         = held_r.body_y;
    q_data.bx         = in_data.body_x;
    q_data.by         = in_data.body_y;
    q_data.c1x        = cax;
    q_data.c1y        = cay;
    q_data.c2x        = cbx;
    q_data.c2y        = cby;

    if (!mask_ok) begin
      q_data.kind = KIND_NONE;
    end else if (!a_rect && !b_rect) begin
      q_data.kind = KIND_CC;
    end else if (a_rect && b_rect) begin
      q_data.kind = KIND_RR;
    end else begin
      q_data.kind = KIND_CR;
    end

    case (q_data.kind)
      KIND_CC: begin
        // The second circle is pushed along the normal, the first against it.
        q_data.lim        = LW'(held_r.size_len) + LW'(in_data.size_len);
        q_data.plus_first = 1'b0;
        if (held_r.body_static) begin
          q_data.mode = MODE_PLUS_FULL;
        end else if (in_data.body_static) begin
          q_data.mode = MODE_MINUS_FULL;
        end
      end
      KIND_RR: begin
        // Extents here are the sums of both half extents.
        q_data.ex         = (held_r.size_len >> 1) + (in_data.size_len >> 1);
        q_data.ey         = (held_r.size_wid >> 1) + (in_data.size_wid >> 1);
        q_data.plus_first = 1'b1;
        if (held_r.body_static) begin
          q_data.mode = MODE_MINUS_FULL;
        end else if (in_data.body_static) begin
          q_data.mode = MODE_PLUS_FULL;
        end
      end
      KIND_CR: begin
        // Center 1 is the rectangle, center 2 the circle.
        if (a_rect) begin
          q_data.ex         = held_r.size_len >> 1;
          q_data.ey         = held_r.size_wid >> 1;
          q_data.lim        = LW'(in_data.size_len);
          q_data.plus_first = 1'b0;
        end else begin
          q_data.c1x        = cbx;
          q_data.c1y        = cby;
          q_data.c2x        = cax;
          q_data.c2y        = cay;
          q_data.ex         = in_data.size_len >> 1;
          q_data.ey         = in_data.size_wid >> 1;
          q_data.lim        = LW'(held_r.size_len);
          q_data.plus_first = 1'b1;
        end
        if (circ_stat) begin
          q_data.mode = MODE_MINUS_FULL;
        end else if (rect_stat) begin
          q_data.mode = MODE_PLUS_FULL;
        end
      end
      default: begin
        q_data.mode = MODE_HALF;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> sv/pcr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_queue: short job queue
// Decouples classification from resolution so either side can stall alone.
// ----------------------------------------------------------------------------
module pcr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pcr_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output pcr_pkg::job_t pop_data
);
  import pcr_pkg::*;

  job_t           slots_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW-1:0] rd_ptr_nxt;
  logic [QAW:0]   cnt_r;
  logic [QAW:0]   cnt_nxt;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slots_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH-1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH-1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> sv/pcr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_back: collision test and pushout sequencer
// Runs one job at a time: deltas, then the box overlap test or squares,
// square root, two restoring divisions, scaling; then saturated positions.
// ----------------------------------------------------------------------------
module pcr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  output logic          q_pop,
  input  pcr_pkg::job_t q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pcr_pkg::out_t out_data
);
  import pcr_pkg::*;

  back_state_t          state_r;
  back_state_t          state_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_load;
  out_t                 out_r;
  out_t                 out_nxt;

  job_t                 job_r;
  logic signed [DW-1:0] dx_r;
  logic signed [DW-1:0] dy_r;
  logic signed [DW-1:0] hix_r;
  logic signed [DW-1:0] hiy_r;
  logic [SQW-1:0]       acc_r;
  logic [SQW-1:0]       prd_r;
  logic [SSW-1:0]       s_r;
  logic [SSW-1:0]       r_r;
  logic [SSW-1:0]       bit_r;
  logic [CNTW-1:0]      cnt_r;
  logic [RTW-1:0]       dist_r;
  logic [LW-1:0]        depth_r;
  logic                 hit_r;
  logic [REMW-1:0]      rem_r;
  logic [REMW-1:0]      den_r;
  logic [NW-1:0]        q_r;
  logic                 divy_r;
  logic [NW-1:0]        nxm_r;
  logic [NW-1:0]        nym_r;
  logic                 negx_r;
  logic                 negy_r;
  logic [RAWW-1:0]      rawx_r;
  logic [RAWW-1:0]      rawy_r;

  logic [MGW-1:0]       mop_a;
  logic [MGW-1:0]       mop_b;
  logic [SQW-1:0]       prod;
  logic [SSW-1:0]       root_t;
  logic                 root_ge;
  logic [RTW-1:0]       dist_c;
  logic                 hit_c;
  logic [LW-1:0]        depth_c;
  logic                 div_ge;
  logic [NW-1:0]        qf;
  logic signed [DW-1:0] ext_x;
  logic signed [DW-1:0] ext_y;

  assign q_pop     = (state_r == BK_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = BK_PREP;
        end
      end
      BK_PREP: begin
        case (job_r.kind)
          KIND_NONE: state_nxt = BK_DONE;
          KIND_RR:   state_nxt = BK_RECT;
          KIND_CR:   state_nxt = BK_CLAMP;
          default:   state_nxt = BK_SQX;
        endcase
      end
      BK_CLAMP: state_nxt = BK_SQX;
      BK_SQX:   state_nxt = BK_SQY;
      BK_SQY:   state_nxt = BK_SUM;
      BK_SUM:   state_nxt = BK_ROOT;
      BK_ROOT: begin
        if (cnt_r == '0) begin
          state_nxt = BK_DECIDE;
        end
      end
      BK_DECIDE: begin
        if (!hit_c) begin
          state_nxt = BK_DONE;
        end else if (dist_c == '0) begin
          state_nxt = BK_MULX;
        end else begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if ((cnt_r == '0) && divy_r) begin
          state_nxt = BK_MULX;
        end
      end
      BK_MULX: state_nxt = BK_MULY;
      BK_MULY: state_nxt = BK_DONE;
      BK_RECT: state_nxt = BK_DONE;
      BK_DONE: begin
        if (out_load) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Output strobes: the result register loads once it is free.
  always_comb begin
    out_load      = (state_r == BK_DONE) && (!out_valid_r || out_ready);
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Shared multiplier for the squares and the normal scaling.
  always_comb begin
    case (state_r)
      BK_SQX: begin
        mop_a = mag_of(dx_r);
        mop_b = mag_of(dx_r);
      end
      BK_SQY: begin
        mop_a = mag_of(dy_r);
        mop_b = mag_of(dy_r);
      end
      BK_MULX: begin
        mop_a = MGW'(nxm_r);
        mop_b = MGW'(depth_r);
      end
      BK_MULY: begin
        mop_a = MGW'(nym_r);
        mop_b = MGW'(depth_r);
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
    prod = SQW'(mop_a) * SQW'(mop_b);
  end

  // Root step, hit decision and divider step.
  assign root_t  = r_r + bit_r;
  assign root_ge = (s_r >= root_t);
  assign dist_c  = r_r[RTW-1:0];
  assign hit_c   = (job_r.kind == KIND_CC) ? (dist_c < RTW'(job_r.lim))
                                           : (dist_c <= RTW'(job_r.lim));
  assign depth_c = job_r.lim - dist_c[LW-1:0];
  assign div_ge  = (rem_r >= den_r);
  assign qf      = NW'({q_r, div_ge});
  assign ext_x   = DW'($signed({1'b0, job_r.ex}));
  assign ext_y   = DW'($signed({1'b0, job_r.ey}));

  // Datapath registers.
  always_ff @(posedge clk) begin
    logic signed [DW-1:0] cx;
    logic signed [DW-1:0] cy;
    logic signed [DW-1:0] o1;
    logic signed [DW-1:0] o2;
    logic signed [DW-1:0] p1;
    logic signed [DW-1:0] p2;
    logic signed [DW-1:0] ox;
    logic signed [DW-1:0] oy;
    cx = DW'(job_r.c2x);
    cy = DW'(job_r.c2y);
    o1 = dx_r + ext_x;
    o2 = ext_x - dx_r;
    p1 = dy_r + ext_y;
    p2 = ext_y - dy_r;
    ox = (o1 < o2) ? o1 : o2;
    oy = (p1 < p2) ? p1 : p2;
    case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          job_r  <= q_data;
          hit_r  <= 1'b0;
          rawx_r <= '0;
          rawy_r <= '0;
          negx_r <= 1'b0;
          negy_r <= 1'b0;
        end
      end
      BK_PREP: begin
        if (job_r.kind == KIND_CR) begin
          // Rectangle bounds around center 1.
          dx_r  <= DW'(job_r.c1x) - ext_x;
          dy_r  <= DW'(job_r.c1y) - ext_y;
          hix_r <= DW'(job_r.c1x) + ext_x;
          hiy_r <= DW'(job_r.c1y) + ext_y;
        end else begin
          dx_r <= DW'(job_r.c2x) - DW'(job_r.c1x);
          dy_r <= DW'(job_r.c2y) - DW'(job_r.c1y);
        end
      end
      BK_CLAMP: begin
        // Delta from the nearest rectangle point to the circle center.
        if (cx > hix_r) begin
          dx_r <= cx - hix_r;
        end else if (cx < dx_r) begin
          dx_r <= cx - dx_r;
        end else begin
          dx_r <= '0;
        end
        if (cy > hiy_r) begin
          dy_r <= cy - hiy_r;
        end else if (cy < dy_r) begin
          dy_r <= cy - dy_r;
        end else begin
          dy_r <= '0;
        end
      end
      BK_SQX: acc_r <= prod;
      BK_SQY: prd_r <= prod;
      BK_SUM: begin
        s_r   <= SSW'(acc_r) + SSW'(prd_r);
        r_r   <= '0;
        bit_r <= SSW'(1) << (SSW-1);
        cnt_r <= CNTW'(RTW-1);
      end
      BK_ROOT: begin
        if (root_ge) begin
          s_r <= s_r - root_t;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - CNTW'(1);
      end
      BK_DECIDE: begin
        dist_r  <= dist_c;
        depth_r <= depth_c;
        hit_r   <= hit_c;
        rem_r   <= REMW'(mag_of(dx_r)) << FRAC;
        den_r   <= REMW'(dist_c) << FRAC;
        q_r     <= '0;
        cnt_r   <= CNTW'(FRAC);
        divy_r  <= 1'b0;
        // Coincident points: zero normal, or straight up for a circle and box.
        nxm_r   <= '0;
        nym_r   <= (job_r.kind == KIND_CR) ? (NW'(1) << FRAC) : '0;
      end
      BK_DIV: begin
        if ((cnt_r == '0) && !divy_r) begin
          // The X quotient is complete; start the Y division.
          nxm_r  <= qf;
          negx_r <= dx_r[DW-1];
          rem_r  <= REMW'(mag_of(dy_r)) << FRAC;
          den_r  <= REMW'(dist_r) << FRAC;
          q_r    <= '0;
          cnt_r  <= CNTW'(FRAC);
          divy_r <= 1'b1;
        end else begin
          if (div_ge) begin
            rem_r <= rem_r - den_r;
          end
          q_r   <= qf;
          den_r <= den_r >> 1;
          cnt_r <= cnt_r - CNTW'(1);
          if (cnt_r == '0) begin
            nym_r  <= qf;
            negy_r <= dy_r[DW-1];
          end
        end
      end
      BK_MULX: rawx_r <= RAWW'(prod);
      BK_MULY: rawy_r <= RAWW'(prod);
      BK_RECT: begin
        // Touching edges count; push on the axis of least overlap, ties to Y.
        hit_r <= !(o1[DW-1] || o2[DW-1] || p1[DW-1] || p2[DW-1]);
        if (!(o1[DW-1] || o2[DW-1] || p1[DW-1] || p2[DW-1])) begin
          if (ox < oy) begin
            rawx_r <= RAWW'($unsigned(ox)) << FRAC;
            negx_r <= (job_r.ax < job_r.bx);
          end else begin
            rawy_r <= RAWW'($unsigned(oy)) << FRAC;
            negy_r <= (job_r.ay < job_r.by);
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  // Final positions: scale the move, pick who moves, add and saturate.
  always_comb begin
    logic [MAGW-1:0]      magx;
    logic [MAGW-1:0]      magy;
    logic signed [PW-1:0] dvx;
    logic signed [PW-1:0] dvy;
    logic signed [PW-1:0] plusx;
    logic signed [PW-1:0] plusy;
    logic signed [PW-1:0] minusx;
    logic signed [PW-1:0] minusy;
    logic signed [PW-1:0] fdx;
    logic signed [PW-1:0] fdy;
    logic signed [PW-1:0] sdx;
    logic signed [PW-1:0] sdy;
    logic                 plus_mv;
    logic                 minus_mv;
    if (job_r.mode == MODE_HALF) begin
      magx = MAGW'(rawx_r >> (FRAC + 1));
      magy = MAGW'(rawy_r >> (FRAC + 1));
    end else begin
      magx = MAGW'(rawx_r >> FRAC);
      magy = MAGW'(rawy_r >> FRAC);
    end
    dvx      = negx_r ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
    dvy      = negy_r ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
    plus_mv  = hit_r && (job_r.mode != MODE_MINUS_FULL);
    minus_mv = hit_r && (job_r.mode != MODE_PLUS_FULL);
    plusx    = plus_mv ? dvx : '0;
    plusy    = plus_mv ? dvy : '0;
    minusx   = minus_mv ? -dvx : '0;
    minusy   = minus_mv ? -dvy : '0;
    fdx      = job_r.plus_first ? plusx : minusx;
    fdy      = job_r.plus_first ? plusy : minusy;
    sdx      = job_r.plus_first ? minusx : plusx;
    sdy      = job_r.plus_first ? minusy : plusy;

    out_nxt.collided     = hit_r;
    out_nxt.pair_kind    = job_r.kind;
    out_nxt.first_new_x  = sat_pos(SUMW'(job_r.ax) + SUMW'(fdx));
    out_nxt.first_new_y  = sat_pos(SUMW'(job_r.ay) + SUMW'(fdy));
    out_nxt.second_new_x = sat_pos(SUMW'(job_r.bx) + SUMW'(sdx));
    out_nxt.second_new_y = sat_pos(SUMW'(job_r.by) + SUMW'(sdy));
  end

`ifndef SYNTHESIS
  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job taken from an empty queue");

  a_load_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == BK_IDLE) && out_valid_r)
    else $error("result load did not finish the job");

  a_hit_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.collided) |-> (out_r.pair_kind != KIND_NONE))
    else $error("collision reported for a rejected pair");

  a_root_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SUM) |=> (state_r == BK_ROOT) && (cnt_r == CNTW'(RTW-1)))
    else $error("square root started with a wrong step count");
`endif

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the pair collision resolver
// Sends body words in pairs, predicts each pair result with an in-bench
// model of the pushout arithmetic, and compares every result word in order.
// ----------------------------------------------------------------------------
module tb_top;
  import pcr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  pair_collision_resolver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state: the held first body.
  in_t     held_body;
  out_t    pending_results[$];
  int      error_count;
  int      idle_cycles;
  bit      idle_enable;
  bit      timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mismatch report: one line per failure.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic longint abs_of(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // Signed division truncated toward zero by a positive divisor.
  function automatic longint trunc_div(input longint num, input longint den);
    longint q;
    q = abs_of(num) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint int_sqrt(input longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Returns 0 when the deltas are too large to count as a hit.
  function automatic bit center_distance(input longint dx, input longint dy,
                                         output longint span);
    longint unsigned ux;
    longint unsigned uy;
    longint unsigned s;
    ux = abs_of(dx);
    uy = abs_of(dy);
    span = 0;
    if (ux >= (64'd1 << 32) || uy >= (64'd1 << 32)) return 1'b0;
    s = ux * ux + uy * uy;
    if (s < ux * ux) return 1'b0;
    span = int_sqrt(s);
    return 1'b1;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic logic signed [CW-1:0] saturate(input longint v);
    longint hi;
    hi = (longint'(1) << (CW - 1)) - 1;
    if (v > hi) return CW'(hi);
    if (v < -hi - 1) return CW'(-hi - 1);
    return CW'(v);
  endfunction

  // Pushout of one pair: first body a against second body b.
  function automatic out_t resolve_pair(input in_t a, input in_t b);
    out_t   r;
    longint ax, ay, bx, by, cax, cay, cbx, cby, dx, dy, span, depth, nx, ny;
    longint ol, orr, oxv, oyv, mx, my, rcx, rcy, ccx, ccy, hx, hy, rad;
    longint mcx, mcy, mrx, mry;
    longint ha, va, hb, vb;
    longint full, half;
    bit     c_stat, r_stat;
    in_t    rc, cc;
    full = longint'(1) << FRAC;
    half = longint'(1) << (FRAC + 1);
    ax = 0; ay = 0; bx = 0; by = 0;
    r = '0;
    r.pair_kind = KIND_NONE;
    if ((a.body_mask & b.body_mask) != 0) begin
      cax = longint'(a.body_x) + longint'(a.offset_x);
      cay = longint'(a.body_y) + longint'(a.offset_y);
      cbx = longint'(b.body_x) + longint'(b.offset_x);
      cby = longint'(b.body_y) + longint'(b.offset_y);
      if (a.body_kind == SHAPE_CIRCLE && b.body_kind == SHAPE_CIRCLE) begin
        r.pair_kind = KIND_CC;
        dx = cbx - cax;
        dy = cby - cay;
        rad = longint'(a.size_len) + longint'(b.size_len);
        if (center_distance(dx, dy, span) && span < rad) begin
          r.collided = 1'b1;
          depth = rad - span;
          nx = 0; ny = 0;
          if (span != 0) begin
            nx = trunc_div(dx * full, span);
            ny = trunc_div(dy * full, span);
          end
          if (a.body_static) begin
            bx = trunc_div(nx * depth, full); by = trunc_div(ny * depth, full);
          end else if (b.body_static) begin
            ax = -trunc_div(nx * depth, full); ay = -trunc_div(ny * depth, full);
          end else begin
            bx = trunc_div(nx * depth, half); by = trunc_div(ny * depth, half);
            ax = -bx; ay = -by;
          end
        end
      end else if (a.body_kind == SHAPE_RECT && b.body_kind == SHAPE_RECT) begin
        r.pair_kind = KIND_RR;
        ha = longint'(a.size_len >> 1);
        va = longint'(a.size_wid >> 1);
        hb = longint'(b.size_len >> 1);
        vb = longint'(b.size_wid >> 1);
        if (!((cax + ha) < (cbx - hb) || (cax - ha) > (cbx + hb) ||
              (cay - va) > (cby + vb) || (cay + va) < (cby - vb))) begin
          r.collided = 1'b1;
          ol  = (cbx + hb) - (cax - ha);
          orr = (cax + ha) - (cbx - hb);
          oxv = ol < orr ? ol : orr;
          ol  = (cby + vb) - (cay - va);
          orr = (cay + va) - (cby - vb);
          oyv = ol < orr ? ol : orr;
          mx = 0; my = 0;
          if (oxv < oyv) mx = (a.body_x < b.body_x) ? -oxv : oxv;
          else           my = (a.body_y < b.body_y) ? -oyv : oyv;
          if (a.body_static) begin
            bx = -mx; by = -my;
          end else if (b.body_static) begin
            ax = mx; ay = my;
          end else begin
            ax = trunc_div(mx, 2); ay = trunc_div(my, 2); bx = -ax; by = -ay;
          end
        end
      end else begin
        r.pair_kind = KIND_CR;
        rc = a.body_kind ? a : b;
        cc = a.body_kind ? b : a;
        rcx = longint'(rc.body_x) + longint'(rc.offset_x);
        rcy = longint'(rc.body_y) + longint'(rc.offset_y);
        ccx = longint'(cc.body_x) + longint'(cc.offset_x);
        ccy = longint'(cc.body_y) + longint'(cc.offset_y);
        hx = longint'(rc.size_len >> 1);
        hy = longint'(rc.size_wid >> 1);
        dx = ccx - clamp_to(ccx, rcx - hx, rcx + hx);
        dy = ccy - clamp_to(ccy, rcy - hy, rcy + hy);
        c_stat = cc.body_static;
        r_stat = rc.body_static;
        if (center_distance(dx, dy, span) && span <= longint'(cc.size_len)) begin
          r.collided = 1'b1;
          depth = longint'(cc.size_len) - span;
          nx = 0; ny = full;
          mcx = 0; mcy = 0; mrx = 0; mry = 0;
          if (span != 0) begin
            nx = trunc_div(dx * full, span);
            ny = trunc_div(dy * full, span);
          end
          if (c_stat) begin
            mrx = -trunc_div(nx * depth, full); mry = -trunc_div(ny * depth, full);
          end else if (r_stat) begin
            mcx = trunc_div(nx * depth, full); mcy = trunc_div(ny * depth, full);
          end else begin
            mcx = trunc_div(nx * depth, half); mcy = trunc_div(ny * depth, half);
            mrx = -mcx; mry = -mcy;
          end
          if (a.body_kind) begin
            ax = mrx; ay = mry; bx = mcx; by = mcy;
          end else begin
            ax = mcx; ay = mcy; bx = mrx; by = mry;
          end
        end
      end
    end
    r.first_new_x  = saturate(longint'(a.body_x) + ax);
    r.first_new_y  = saturate(longint'(a.body_y) + ay);
    r.second_new_x = saturate(longint'(b.body_x) + bx);
    r.second_new_y = saturate(longint'(b.body_y) + by);
    return r;
  endfunction

  // Random idle burst on the sending side; valid drops for the burst.
  task automatic sender_gap();
    int n;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Send one word; the prediction is made when it is accepted.
  // Valid stays high on return, so the caller either sends again or drops it.
  task automatic send_word(input in_t w);
    sender_gap();
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.slot == SLOT_FIRST) held_body = w;
    else pending_results.insert(pending_results.size(), resolve_pair(held_body, w));
    @(negedge clk);
  endtask

  function automatic in_t make_body(input bit slot, input bit kind, input int x, input int y,
                                    input int ox, input int oy, input int len, input int wid,
                                    input int mask, input bit stat);
    in_t w;
    w.slot = slot; w.body_kind = kind;
    w.body_x = CW'(x); w.body_y = CW'(y);
    w.offset_x = CW'(ox); w.offset_y = CW'(oy);
    w.size_len = SW'(len); w.size_wid = SW'(wid);
    w.body_mask = MW'(mask); w.body_static = stat;
    return w;
  endfunction

  // Random body near the origin so that most pairs can touch; sometimes full range.
  function automatic in_t random_body(input bit slot);
    in_t          w;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_t)-1:0];
    w.slot = slot;
    if ($urandom_range(0, 9) != 0) begin
      w.body_x   = CW'($signed($urandom_range(0, 8191)) - 4096);
      w.body_y   = CW'($signed($urandom_range(0, 8191)) - 4096);
      w.offset_x = CW'($signed($urandom_range(0, 511)) - 256);
      w.offset_y = CW'($signed($urandom_range(0, 511)) - 256);
      w.size_len = SW'($urandom_range(0, 4095));
      w.size_wid = SW'($urandom_range(0, 4095));
      if ($urandom_range(0, 7) != 0) w.body_mask = w.body_mask | MW'(1);
    end
    return w;
  endfunction

  // Directed pairs: every pair kind, static combinations and corner cases.
  task automatic test_directed();
    // Second body before any first body: a zero mask, so a reject.
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, 100, 100, 0, 0, 512, 0, 16'hffff, 0));
    // Mask reject with overlapping shapes.
    send_word(make_body(SLOT_FIRST, SHAPE_CIRCLE, 0, 0, 0, 0, 512, 0, 16'h00f0, 0));
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, 10, 0, 0, 0, 512, 0, 16'h0f0f, 0));
    // Circle pair, both movable, then each static.
    send_word(make_body(SLOT_FIRST, SHAPE_CIRCLE, 0, 0, 20, -30, 512, 0, 16'h8000, 0));
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, 300, 200, 0, 0, 512, 0, 16'h8001, 0));
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, 300, 200, 0, 0, 512, 0, 16'h8001, 1));
    send_word(make_body(SLOT_FIRST, SHAPE_CIRCLE, 0, 0, 0, 0, 512, 0, 16'h0001, 1));
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, -300, 200, 0, 0, 512, 0, 16'h0001, 1));
    // Coincident centers: zero normal.
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, 0, 0, 0, 0, 100, 0, 16'h0001, 0));
    // Circle miss.
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, 5000, 0, 0, 0, 100, 0, 16'h0001, 0));
    // Rectangles touching at an edge, and equal overlaps (tie goes to Y).
    send_word(make_body(SLOT_FIRST, SHAPE_RECT, 0, 0, 0, 0, 200, 200, 16'h0002, 0));
    send_word(make_body(SLOT_SECOND, SHAPE_RECT, 200, 0, 0, 0, 200, 200, 16'h0002, 0));
    send_word(make_body(SLOT_SECOND, SHAPE_RECT, 50, 50, 0, 0, 200, 200, 16'h0002, 0));
    send_word(make_body(SLOT_SECOND, SHAPE_RECT, -30, 80, 0, 0, 200, 200, 16'h0002, 1));
    // Circle against rectangle, center inside (distance zero) and outside.
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, 10, 10, 0, 0, 64, 0, 16'h0002, 0));
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, 130, 120, 0, 0, 64, 0, 16'h0002, 0));
    send_word(make_body(SLOT_FIRST, SHAPE_CIRCLE, 130, 0, 0, 0, 64, 0, 16'h0004, 1));
    send_word(make_body(SLOT_SECOND, SHAPE_RECT, 0, 0, 0, 0, 200, 100, 16'h0004, 0));
    // Extremes: saturation and huge deltas.
    send_word(make_body(SLOT_FIRST, SHAPE_CIRCLE, 8388607, -8388608, 8388607, -8388608,
                        8388607, 8388607, 16'hffff, 0));
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, -8388608, 8388607, -8388608, 8388607,
                        8388607, 8388607, 16'hffff, 0));
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, 8388607, -8388608, 8388607, -8388600,
                        8388607, 0, 16'hffff, 0));
    send_word(make_body(SLOT_FIRST, SHAPE_RECT, 8388607, 8388607, 8388607, 8388607,
                        8388607, 8388607, 16'hffff, 1));
    send_word(make_body(SLOT_SECOND, SHAPE_RECT, 8388600, 8388607, 8388607, 8388607,
                        8388607, 8388607, 16'hffff, 0));
  endtask

  // Random pairs, with a few stray and repeated words mixed in.
  task automatic test_random(input int n_words);
    int sent;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(random_body(1'($urandom_range(0, 1))));
        sent++;
      end else begin
        send_word(random_body(SLOT_FIRST));
        send_word(random_body(SLOT_SECOND));
        sent += 2;
        if ($urandom_range(0, 3) == 0) begin
          send_word(random_body(SLOT_SECOND));
          sent++;
        end
      end
    end
  endtask

  // Hold off the sender until the queue of expected results is empty.
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    send_word(make_body(SLOT_FIRST, SHAPE_RECT, 0, 0, 0, 0, 100, 100, 16'h0001, 0));
    send_word(make_body(SLOT_SECOND, SHAPE_CIRCLE, 40, 40, 0, 0, 30, 0, 16'h0001, 0));
  endtask

  // Result checker: compares each accepted word with the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.collided !== want.collided)
          report_mismatch("collided", out_data.collided, want.collided);
        if (out_data.pair_kind !== want.pair_kind)
          report_mismatch("pair_kind", out_data.pair_kind, want.pair_kind);
        if (out_data.first_new_x !== want.first_new_x)
          report_mismatch("first_new_x", out_data.first_new_x, want.first_new_x);
        if (out_data.first_new_y !== want.first_new_y)
          report_mismatch("first_new_y", out_data.first_new_y, want.first_new_y);
        if (out_data.second_new_x !== want.second_new_x)
          report_mismatch("second_new_x", out_data.second_new_x, want.second_new_x);
        if (out_data.second_new_y !== want.second_new_y)
          report_mismatch("second_new_y", out_data.second_new_y, want.second_new_y);
      end
    end
  end

  // Receiver stalls in random bursts.
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int waited;
    error_count = 0;
    idle_cycles = 0;
    timed_out   = 1'b0;
    idle_enable = 1'b1;
    held_body   = '0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(300);
    test_drain_pause();
    test_random(100);
    idle_enable = 1'b0;
    test_random(100);
    in_valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < WATCHDOG_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
